### rtl/cwi_pkg.sv
// Shared types and constants of the cyclic waypoint interpolator.
`timescale 1ns / 1ps

package cwi_pkg;

    // Store geometry.
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    // The remainder register holds twice the largest remainder plus one.
    localparam int REM_W      = $clog2(2 * MAX_POINTS);

    // Fixed point widths of the beat fields.
    localparam int COORD_W    = 32;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int SCALED_W   = TIME_W + SPEED_W;
    localparam int IPART_W    = 24;
    localparam int WORD_W     = 3 * COORD_W;

    // Reset value of the speed register, 1.0 in Q8.8.
    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

    // The remainder unit consumes this many bits of the integer part per cycle.
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = IPART_W / DIV_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_TOGGLE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_RDA   = 6'b000100,
        S_RDB   = 6'b001000,
        S_BLEND = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

### rtl/cyclic_waypoint_interpolator_core.sv
// Cyclic waypoint interpolator: waypoint memory, tick sequencer and blend datapath.
`timescale 1ns / 1ps

// Channel   | valid        | stall        | payload
// ----------+--------------+--------------+------------------------------------------
// input     | i_in_valid   | o_in_stall   | i_cmd, i_time_now, i_point_x/y/z
// output    | o_out_valid  | i_out_stall  | o_pos_x/y/z, o_is_animating, o_count_out,
//           |              |              | o_status
// config    | i_cfg_we     | none         | i_cfg_data (speed, Q8.8)
//
// Add, clear, toggle and a tick while not animating load the output register as
// the beat is accepted. A tick while animating runs from accept to the next
// accept through the time by speed product registered at accept, the steps of
// the remainder unit that takes 4 bits of the 24-bit integer part per cycle, 2
// reads on the single read port of the waypoint memory, the blend phases through
// the one shared blend multiplier, and the load of the output register when free.
// Reset is synchronous and active low; the waypoint memory is not cleared.
// A new beat enters only when the output register is empty or is read in the
// same cycle, so a result held by i_out_stall also stalls the input.

module cyclic_waypoint_interpolator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cwi_pkg::SPEED_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_cmd,
    input  logic [cwi_pkg::TIME_W-1:0]           i_time_now,
    input  logic signed [cwi_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [cwi_pkg::COORD_W-1:0]   i_point_y,
    input  logic signed [cwi_pkg::COORD_W-1:0]   i_point_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [cwi_pkg::COORD_W-1:0]   o_pos_x,
    output logic signed [cwi_pkg::COORD_W-1:0]   o_pos_y,
    output logic signed [cwi_pkg::COORD_W-1:0]   o_pos_z,
    output logic                                 o_is_animating,
    output logic [cwi_pkg::CNT_W-1:0]            o_count_out,
    output logic [1:0]                           o_status
);

    cwi_pkg::t_state                      r_state;
    cwi_pkg::t_state                      n_state;
    logic [cwi_pkg::SPEED_W-1:0]          r_speed;
    logic [cwi_pkg::CNT_W-1:0]            r_count;
    logic [cwi_pkg::CNT_W-1:0]            n_count;
    logic                                 r_anim;
    logic                                 n_anim;
    cwi_pkg::t_status                     w_status;
    logic                                 w_start_tick;

    logic [cwi_pkg::COORD_W-1:0]          r_pos_x;
    logic [cwi_pkg::COORD_W-1:0]          r_pos_y;
    logic [cwi_pkg::COORD_W-1:0]          r_pos_z;

    logic [cwi_pkg::WORD_W-1:0]           r_mem [cwi_pkg::MAX_POINTS];
    logic [cwi_pkg::WORD_W-1:0]           r_rd_data;
    logic                                 w_rd_en;
    logic [cwi_pkg::IDX_W-1:0]            w_rd_addr;
    logic                                 w_wr_en;

    logic [cwi_pkg::SCALED_W-1:0]         w_scaled;
    logic [cwi_pkg::IPART_W-1:0]          r_ipart;
    logic [cwi_pkg::FRAC_W-1:0]           r_frac;
    logic [cwi_pkg::REM_W-1:0]            r_rem;
    logic [cwi_pkg::REM_W-1:0]            w_rem;
    logic [cwi_pkg::STEP_W-1:0]           r_step;
    logic [cwi_pkg::IDX_W-1:0]            w_cur;
    logic [cwi_pkg::IDX_W-1:0]            w_next;
    logic [cwi_pkg::IDX_W-1:0]            r_next;

    logic [cwi_pkg::WORD_W-1:0]           r_way_a;
    logic [1:0]                           r_phase;
    logic [cwi_pkg::COORD_W-1:0]          w_a_mul;
    logic [cwi_pkg::COORD_W-1:0]          w_b_mul;
    logic [cwi_pkg::COORD_W-1:0]          w_a_add;
    logic signed [cwi_pkg::COORD_W:0]     w_diff;
    logic signed [cwi_pkg::FRAC_W:0]      w_frac_s;
    logic signed [49:0]                   w_blend_p;
    logic signed [49:0]                   r_blend_p;
    logic signed [49:0]                   w_q;
    logic [cwi_pkg::COORD_W:0]            w_sum;

    logic                                 w_out_free;
    logic                                 w_in_acc;
    logic                                 w_out_load;
    logic                                 r_out_valid;
    logic [cwi_pkg::COORD_W-1:0]          r_out_x;
    logic [cwi_pkg::COORD_W-1:0]          r_out_y;
    logic [cwi_pkg::COORD_W-1:0]          r_out_z;
    logic                                 r_out_anim;
    logic [cwi_pkg::CNT_W-1:0]            r_out_count;
    cwi_pkg::t_status                     r_out_status;

    // Handshake: a beat enters only in idle with room in the output register.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == cwi_pkg::S_IDLE) && w_out_free);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Command decode for the beat at the input.
    always_comb begin
        n_count      = r_count;
        n_anim       = r_anim;
        w_status     = cwi_pkg::STATUS_OK;
        w_start_tick = 1'b0;
        w_wr_en      = 1'b0;
        case (cwi_pkg::t_cmd'(i_cmd))
            cwi_pkg::CMD_TICK: begin
                w_start_tick = r_anim && (r_count >= cwi_pkg::CNT_W'(2));
            end
            cwi_pkg::CMD_ADD: begin
                if (r_count < cwi_pkg::CNT_W'(cwi_pkg::MAX_POINTS)) begin
                    w_wr_en = w_in_acc;
                    n_count = r_count + cwi_pkg::CNT_W'(1);
                end else begin
                    w_status = cwi_pkg::STATUS_FULL;
                end
            end
            cwi_pkg::CMD_CLEAR: begin
                n_count = '0;
                n_anim  = 1'b0;
            end
            cwi_pkg::CMD_TOGGLE: begin
                if (r_count >= cwi_pkg::CNT_W'(2)) begin
                    n_anim = !r_anim;
                end else begin
                    w_status = cwi_pkg::STATUS_SHORT;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Scaled time in Q24.24.
    assign w_scaled = cwi_pkg::SCALED_W'(i_time_now) * cwi_pkg::SCALED_W'(r_speed);

    // Remainder unit: four restoring steps over the next bits of the integer part.
    always_comb begin
        w_rem = r_rem;
        for (int i = 0; i < cwi_pkg::DIV_BITS; i++) begin
            w_rem = {w_rem[cwi_pkg::REM_W-2:0], r_ipart[cwi_pkg::IPART_W-1-i]};
            if (w_rem >= cwi_pkg::REM_W'(r_count)) begin
                w_rem = w_rem - cwi_pkg::REM_W'(r_count);
            end
        end
    end

    // Current segment and its cyclic successor.
    assign w_cur  = r_rem[cwi_pkg::IDX_W-1:0];
    assign w_next = ((cwi_pkg::REM_W'(w_cur) + cwi_pkg::REM_W'(1))
                     == cwi_pkg::REM_W'(r_count))
                    ? '0 : (w_cur + cwi_pkg::IDX_W'(1));

    // Memory read port control.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_cur;
        if (r_state == cwi_pkg::S_RDA) begin
            w_rd_en = 1'b1;
        end else if (r_state == cwi_pkg::S_RDB) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_next;
        end
    end

    // Waypoint memory, one word of three coordinates per entry.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[cwi_pkg::IDX_W-1:0]] <= {i_point_z, i_point_y, i_point_x};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Axis selection for the multiply stage and for the add stage in the phase after it.
    always_comb begin
        w_a_mul = r_way_a[cwi_pkg::COORD_W-1:0];
        w_b_mul = r_rd_data[cwi_pkg::COORD_W-1:0];
        w_a_add = r_way_a[cwi_pkg::COORD_W-1:0];
        case (r_phase)
            2'd0: begin
                w_a_mul = r_way_a[cwi_pkg::COORD_W-1:0];
                w_b_mul = r_rd_data[cwi_pkg::COORD_W-1:0];
            end
            2'd1: begin
                w_a_mul = r_way_a[2*cwi_pkg::COORD_W-1:cwi_pkg::COORD_W];
                w_b_mul = r_rd_data[2*cwi_pkg::COORD_W-1:cwi_pkg::COORD_W];
            end
            2'd2: begin
                w_a_mul = r_way_a[3*cwi_pkg::COORD_W-1:2*cwi_pkg::COORD_W];
                w_b_mul = r_rd_data[3*cwi_pkg::COORD_W-1:2*cwi_pkg::COORD_W];
                w_a_add = r_way_a[2*cwi_pkg::COORD_W-1:cwi_pkg::COORD_W];
            end
            default: begin
                w_a_add = r_way_a[3*cwi_pkg::COORD_W-1:2*cwi_pkg::COORD_W];
            end
        endcase
    end

    // Blend datapath: (b - a) * t, then a + floor(product / 65536).
    assign w_diff    = $signed({w_b_mul[cwi_pkg::COORD_W-1], w_b_mul})
                     - $signed({w_a_mul[cwi_pkg::COORD_W-1], w_a_mul});
    assign w_frac_s  = $signed({1'b0, r_frac});
    assign w_blend_p = w_diff * w_frac_s;
    assign w_q       = r_blend_p >>> cwi_pkg::FRAC_W;
    assign w_sum     = w_q[cwi_pkg::COORD_W:0]
                     + {w_a_add[cwi_pkg::COORD_W-1], w_a_add};

    // Output register loads on a short command or at the end of a tick.
    assign w_out_load = (w_in_acc && !w_start_tick)
                     || ((r_state == cwi_pkg::S_DONE) && w_out_free);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cwi_pkg::S_IDLE: begin
                if (w_in_acc && w_start_tick) begin
                    n_state = cwi_pkg::S_DIV;
                end
            end
            cwi_pkg::S_DIV: begin
                if (r_step == cwi_pkg::STEP_W'(cwi_pkg::DIV_STEPS - 1)) begin
                    n_state = cwi_pkg::S_RDA;
                end
            end
            cwi_pkg::S_RDA: begin
                n_state = cwi_pkg::S_RDB;
            end
            cwi_pkg::S_RDB: begin
                n_state = cwi_pkg::S_BLEND;
            end
            cwi_pkg::S_BLEND: begin
                if (r_phase == 2'd3) begin
                    n_state = cwi_pkg::S_DONE;
                end
            end
            cwi_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = cwi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cwi_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwi_pkg::S_IDLE;
            r_speed     <= cwi_pkg::SPEED_RESET;
            r_count     <= '0;
            r_anim      <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_speed <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_count <= n_count;
                r_anim  <= n_anim;
            end
            // Held position is written by the add stage of the blend.
            if (r_state == cwi_pkg::S_BLEND) begin
                case (r_phase)
                    2'd1:    r_pos_x <= w_sum[cwi_pkg::COORD_W-1:0];
                    2'd2:    r_pos_y <= w_sum[cwi_pkg::COORD_W-1:0];
                    2'd3:    r_pos_z <= w_sum[cwi_pkg::COORD_W-1:0];
                    default: r_pos_x <= r_pos_x;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Tick datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ipart <= w_scaled[cwi_pkg::SCALED_W-1:cwi_pkg::SCALED_W-cwi_pkg::IPART_W];
            r_frac  <= w_scaled[cwi_pkg::SCALED_W-cwi_pkg::IPART_W-1:
                                cwi_pkg::SCALED_W-cwi_pkg::IPART_W-cwi_pkg::FRAC_W];
            r_rem   <= '0;
            r_step  <= '0;
        end else if (r_state == cwi_pkg::S_DIV) begin
            r_rem   <= w_rem;
            r_ipart <= {r_ipart[cwi_pkg::IPART_W-cwi_pkg::DIV_BITS-1:0],
                        cwi_pkg::DIV_BITS'(0)};
            r_step  <= r_step + cwi_pkg::STEP_W'(1);
        end
        if (r_state == cwi_pkg::S_RDA) begin
            r_next <= w_next;
        end
        if (r_state == cwi_pkg::S_RDB) begin
            r_way_a <= r_rd_data;
            r_phase <= '0;
        end else if (r_state == cwi_pkg::S_BLEND) begin
            r_phase   <= r_phase + 2'd1;
            r_blend_p <= w_blend_p;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_state == cwi_pkg::S_DONE) begin
                r_out_anim   <= r_anim;
                r_out_count  <= r_count;
                r_out_status <= cwi_pkg::STATUS_OK;
            end else begin
                r_out_anim   <= n_anim;
                r_out_count  <= n_count;
                r_out_status <= w_status;
            end
            r_out_x <= r_pos_x;
            r_out_y <= r_pos_y;
            r_out_z <= r_pos_z;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pos_x        = $signed(r_out_x);
    assign o_pos_y        = $signed(r_out_y);
    assign o_pos_z        = $signed(r_out_z);
    assign o_is_animating = r_out_anim;
    assign o_count_out    = r_out_count;
    assign o_status       = r_out_status;

`ifndef ASSERT_OFF
    // The fill count never passes the store depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cwi_pkg::CNT_W'(cwi_pkg::MAX_POINTS))
        else $error("waypoint count beyond store depth");

    // Animation only runs with at least two waypoints stored.
    a_anim_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_anim |-> (r_count >= cwi_pkg::CNT_W'(2)))
        else $error("animating with fewer than two waypoints");

    // The segment read from memory lies below the fill count.
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cwi_pkg::S_RDA) |-> (r_rem < cwi_pkg::REM_W'(r_count)))
        else $error("segment index outside stored waypoints");

    // A tick in progress leaves the fill count untouched until its result loads.
    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cwi_pkg::S_BLEND) |=> $stable(r_count))
        else $error("fill count changed during a tick");
`endif

endmodule
